[rtl/tcet_pkg.sv]
// shared types and constants for the touch contact event tracker
`timescale 1ns / 1ps

package tcet_pkg;

    // default table depth
    localparam int MAX_CONTACTS_DEF = 16;

    // field widths
    localparam int ID_W    = 8;
    localparam int POS_W   = 16;
    localparam int SIZE_W  = 16;
    localparam int SCALE_W = 14;
    localparam int SCR_W   = 13;
    localparam int SSIZE_W = 21;
    localparam int KIND_W  = 3;
    localparam int PROD_W  = POS_W + SCALE_W;

    // configuration registers
    localparam logic [0:0] CFG_SCREEN_WIDTH  = 1'd0;
    localparam logic [0:0] CFG_SCREEN_HEIGHT = 1'd1;
    localparam logic [SCALE_W-1:0] SCREEN_WIDTH_RST  = 14'd1920;
    localparam logic [SCALE_W-1:0] SCREEN_HEIGHT_RST = 14'd1080;

    // size scale factor
    localparam logic [SCALE_W-1:0] SIZE_FACTOR = 14'd30;

    // input commands
    localparam logic CMD_CONTACT   = 1'b0;
    localparam logic CMD_END_FRAME = 1'b1;

    // event codes
    localparam logic [KIND_W-1:0] EV_ENTER = 3'd0;
    localparam logic [KIND_W-1:0] EV_DOWN  = 3'd1;
    localparam logic [KIND_W-1:0] EV_MOVE  = 3'd2;
    localparam logic [KIND_W-1:0] EV_UP    = 3'd3;
    localparam logic [KIND_W-1:0] EV_LEAVE = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_FIND,
        ST_LOAD,
        ST_MUL,
        ST_EMIT,
        ST_SWAP
    } tcet_state_t;

    // request to the shared scaling unit
    typedef struct packed {
        logic [POS_W-1:0]   operand;
        logic [SCALE_W-1:0] factor;
        logic               sat;
    } scale_req_t;

endpackage

[rtl/tcet_scale_unit.sv]
// shared multiplier with optional position scaling and saturation, registered result
`timescale 1ns / 1ps

module tcet_scale_unit
    import tcet_pkg::*;
(
    input  logic               aclk,
    input  scale_req_t         req,
    output logic [SSIZE_W-1:0] result
);

    logic [PROD_W-1:0]      product;
    logic [SCALE_W-1:0]     pix;
    logic [SSIZE_W-1:0]     result_reg;
    logic [SSIZE_W-1:0]     result_next;

    assign product = PROD_W'(req.operand) * PROD_W'(req.factor);
    assign pix     = product[PROD_W-1:POS_W];

    always_comb begin
        if (req.sat) begin
            // position path: keep the pixel part, clamp to 13 bits
            if (pix > SCALE_W'({SCR_W{1'b1}})) begin
                result_next = SSIZE_W'({SCR_W{1'b1}});
            end else begin
                result_next = SSIZE_W'(pix);
            end
        end else begin
            result_next = product[SSIZE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

[rtl/touch_contact_event_tracker_core.sv]
// top level of the touch contact event tracker
`timescale 1ns / 1ps

// Touch contact event tracker. Contacts of a frame come in one transaction each
// (s_cmd = 0); a frame closes with an end-of-frame transaction (s_cmd = 1). A
// contact whose id sat in the previous frame and is not matched yet gives one
// move event, any other contact gives enter then down; it is stored in the
// current table (a repeated id overwrites its entry, a new id with the table
// full sets m_table_full and is dropped). End of frame gives up then leave for
// each unmatched previous contact in ascending id order, then the current
// table becomes the previous one. m_last marks the final event of a
// transaction; an end of frame with nothing unmatched gives no event.
// Timing: one sequencer walks the tables one entry per cycle and a single
// 16x14 multiplier forms x, y and size one after another; an output stall
// holds the sequencer in its emit state. s_ready is high only while the
// sequencer is idle. Configuration: index 0 screen width, index 1 screen
// height; the user must write them only while the block is idle, which the
// block itself does not enforce; cfg_ready is always high.

module touch_contact_event_tracker_core
    import tcet_pkg::*;
#(
    parameter int MAX_CONTACTS = MAX_CONTACTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,

    // contact / end-of-frame input
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_cmd,
    input  logic [ID_W-1:0]     s_contact_id,
    input  logic [POS_W-1:0]    s_pos_x,
    input  logic [POS_W-1:0]    s_pos_y,
    input  logic [SIZE_W-1:0]   s_contact_size,

    // event output
    output logic                m_valid,
    input  logic                m_ready,
    output logic [KIND_W-1:0]   m_event_kind,
    output logic [ID_W-1:0]     m_event_id,
    output logic [SCR_W-1:0]    m_screen_x,
    output logic [SCR_W-1:0]    m_screen_y,
    output logic [SSIZE_W-1:0]  m_scaled_size,
    output logic                m_table_full,
    output logic                m_last,

    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [SCALE_W-1:0]  cfg_data
);

    localparam int IDX_W = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
    localparam int CNT_W = $clog2(MAX_CONTACTS + 1);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MAX_CONTACTS - 1);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    // sequencer
    tcet_state_t state_reg, state_next;

    // configuration
    logic [SCALE_W-1:0] width_reg, width_next;
    logic [SCALE_W-1:0] height_reg, height_next;

    // tables: two banks, cur_sel_reg = 0 means bank a holds the current frame
    logic                    cur_sel_reg, cur_sel_next;
    logic [MAX_CONTACTS-1:0] valid_a_reg, valid_a_next;
    logic [MAX_CONTACTS-1:0] valid_b_reg, valid_b_next;
    logic [MAX_CONTACTS-1:0] matched_reg, matched_next;
    logic [ID_W-1:0]   ident_a_reg [MAX_CONTACTS];
    logic [ID_W-1:0]   ident_b_reg [MAX_CONTACTS];
    logic [POS_W-1:0]  xpos_a_reg  [MAX_CONTACTS];
    logic [POS_W-1:0]  xpos_b_reg  [MAX_CONTACTS];
    logic [POS_W-1:0]  ypos_a_reg  [MAX_CONTACTS];
    logic [POS_W-1:0]  ypos_b_reg  [MAX_CONTACTS];
    logic [SIZE_W-1:0] csize_a_reg [MAX_CONTACTS];
    logic [SIZE_W-1:0] csize_b_reg [MAX_CONTACTS];

    // table write port
    logic             store_we;
    logic [IDX_W-1:0] store_idx;

    // walk state and working item
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  idx;
    logic [ID_W-1:0]   wid_reg, wid_next;
    logic [POS_W-1:0]  wx_reg, wx_next;
    logic [POS_W-1:0]  wy_reg, wy_next;
    logic [SIZE_W-1:0] wsz_reg, wsz_next;
    logic              wfull_reg, wfull_next;
    logic              end_mode_reg, end_mode_next;
    logic              hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic              dup_found_reg, dup_found_next;
    logic [IDX_W-1:0]  dup_idx_reg, dup_idx_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic              best_found_reg, best_found_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [ID_W-1:0]   best_id_reg, best_id_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              last_grp_reg, last_grp_next;
    logic              phase_reg, phase_next;
    logic [1:0]        mstep_reg, mstep_next;
    logic [SCR_W-1:0]  sx_reg, sx_next;
    logic [SCR_W-1:0]  sy_reg, sy_next;
    logic [SSIZE_W-1:0] ssz_reg, ssz_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]  m_kind_reg, m_kind_next;
    logic [ID_W-1:0]    m_id_reg, m_id_next;
    logic [SCR_W-1:0]   m_x_reg, m_x_next;
    logic [SCR_W-1:0]   m_y_reg, m_y_next;
    logic [SSIZE_W-1:0] m_size_reg, m_size_next;
    logic               m_full_reg, m_full_next;
    logic               m_last_reg, m_last_next;

    // per-entry reads at the walk index and at the chosen entry
    logic [ID_W-1:0]   prev_id, cur_id;
    logic              prev_elig, cur_valid_bit;
    logic [POS_W-1:0]  prev_x, prev_y;
    logic [SIZE_W-1:0] prev_sz;

    // shared scaling unit
    scale_req_t         sreq;
    logic [SSIZE_W-1:0] sres;

    // emit decode
    logic              in_accept;
    logic              out_load;
    logic              emit_final;
    logic [KIND_W-1:0] emit_kind;
    logic              scan_last;
    logic              find_cand;

    assign idx       = idx_reg[IDX_W-1:0];
    assign in_accept = s_valid && s_ready;
    assign scan_last = (idx_reg == LAST_IDX);

    assign prev_id = cur_sel_reg ? ident_a_reg[idx] : ident_b_reg[idx];
    assign cur_id  = cur_sel_reg ? ident_b_reg[idx] : ident_a_reg[idx];
    assign prev_elig = (cur_sel_reg ? valid_a_reg[idx] : valid_b_reg[idx]) && !matched_reg[idx];
    assign cur_valid_bit = cur_sel_reg ? valid_b_reg[idx] : valid_a_reg[idx];

    assign prev_x  = cur_sel_reg ? xpos_a_reg[best_idx_reg]  : xpos_b_reg[best_idx_reg];
    assign prev_y  = cur_sel_reg ? ypos_a_reg[best_idx_reg]  : ypos_b_reg[best_idx_reg];
    assign prev_sz = cur_sel_reg ? csize_a_reg[best_idx_reg] : csize_b_reg[best_idx_reg];

    // smallest unmatched previous id seen so far
    assign find_cand = prev_elig && (!best_found_reg || (prev_id < best_id_reg));

    // output slot free when empty or being taken this cycle
    assign out_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    // event selection for the current emit phase
    always_comb begin
        if (end_mode_reg) begin
            emit_kind  = phase_reg ? EV_LEAVE : EV_UP;
            emit_final = phase_reg;
        end else if (hit_found_reg) begin
            emit_kind  = EV_MOVE;
            emit_final = 1'b1;
        end else begin
            emit_kind  = phase_reg ? EV_DOWN : EV_ENTER;
            emit_final = phase_reg;
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        case (mstep_reg)
            2'd0: begin
                sreq = '{operand: wx_reg, factor: width_reg, sat: 1'b1};
            end
            2'd1: begin
                sreq = '{operand: wy_reg, factor: height_reg, sat: 1'b1};
            end
            default: begin
                sreq = '{operand: wsz_reg, factor: SIZE_FACTOR, sat: 1'b0};
            end
        endcase
    end

    tcet_scale_unit u_scale (
        .aclk   (aclk),
        .req    (sreq),
        .result (sres)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = (s_cmd == CMD_END_FRAME) ? ST_FIND : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                state_next = ST_MUL;
            end
            ST_FIND: begin
                if (scan_last) begin
                    state_next = (best_found_reg || prev_elig) ? ST_LOAD : ST_SWAP;
                end
            end
            ST_LOAD: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (mstep_reg == 2'd3) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load && emit_final) begin
                    state_next = end_mode_reg ? ST_FIND : ST_IDLE;
                end
            end
            ST_SWAP: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and table control
    always_comb begin
        width_next      = width_reg;
        height_next     = height_reg;
        cur_sel_next    = cur_sel_reg;
        valid_a_next    = valid_a_reg;
        valid_b_next    = valid_b_reg;
        matched_next    = matched_reg;
        store_we        = 1'b0;
        store_idx       = dup_found_reg ? dup_idx_reg : free_idx_reg;
        idx_next        = idx_reg;
        wid_next        = wid_reg;
        wx_next         = wx_reg;
        wy_next         = wy_reg;
        wsz_next        = wsz_reg;
        wfull_next      = wfull_reg;
        end_mode_next   = end_mode_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        dup_found_next  = dup_found_reg;
        dup_idx_next    = dup_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_id_next    = best_id_reg;
        count_next      = count_reg;
        last_grp_next   = last_grp_reg;
        phase_next      = phase_reg;
        mstep_next      = mstep_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        ssz_next        = ssz_reg;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  width_next  = cfg_data;
                CFG_SCREEN_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    idx_next        = '0;
                    wid_next        = s_contact_id;
                    wx_next         = s_pos_x;
                    wy_next         = s_pos_y;
                    wsz_next        = s_contact_size;
                    end_mode_next   = (s_cmd == CMD_END_FRAME);
                    hit_found_next  = 1'b0;
                    dup_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    best_found_next = 1'b0;
                    count_next      = '0;
                end
            end
            ST_SCAN: begin
                if (!hit_found_reg && prev_elig && (prev_id == wid_reg)) begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = idx;
                end
                if (!dup_found_reg && cur_valid_bit && (cur_id == wid_reg)) begin
                    dup_found_next = 1'b1;
                    dup_idx_next   = idx;
                end
                if (!free_found_reg && !cur_valid_bit) begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx;
                end
                idx_next = idx_reg + ONE_CNT;
            end
            ST_COMMIT: begin
                // repeated id overwrites its entry, otherwise first free one
                store_we   = dup_found_reg || free_found_reg;
                wfull_next = !(dup_found_reg || free_found_reg);
                if (store_we) begin
                    if (cur_sel_reg) begin
                        valid_b_next[store_idx] = 1'b1;
                    end else begin
                        valid_a_next[store_idx] = 1'b1;
                    end
                end
                if (hit_found_reg) begin
                    matched_next[hit_idx_reg] = 1'b1;
                end
                mstep_next = 2'd0;
            end
            ST_FIND: begin
                if (prev_elig) begin
                    count_next = count_reg + ONE_CNT;
                end
                if (find_cand) begin
                    best_found_next = 1'b1;
                    best_idx_next   = idx;
                    best_id_next    = prev_id;
                end
                idx_next = idx_reg + ONE_CNT;
            end
            ST_LOAD: begin
                // up and leave reuse the stored values; marking it matched
                // takes it out of later searches in this frame end
                wid_next      = best_id_reg;
                wx_next       = prev_x;
                wy_next       = prev_y;
                wsz_next      = prev_sz;
                wfull_next    = 1'b0;
                last_grp_next = (count_reg == ONE_CNT);
                matched_next[best_idx_reg] = 1'b1;
                mstep_next    = 2'd0;
            end
            ST_MUL: begin
                case (mstep_reg)
                    2'd1:    sx_next  = sres[SCR_W-1:0];
                    2'd2:    sy_next  = sres[SCR_W-1:0];
                    2'd3:    ssz_next = sres;
                    default: ;
                endcase
                mstep_next = mstep_reg + 2'd1;
                phase_next = 1'b0;
            end
            ST_EMIT: begin
                if (out_load) begin
                    phase_next = 1'b1;
                    if (emit_final && end_mode_reg) begin
                        idx_next        = '0;
                        best_found_next = 1'b0;
                        count_next      = '0;
                    end
                end
            end
            ST_SWAP: begin
                // current table becomes previous, old previous bank is emptied
                cur_sel_next = !cur_sel_reg;
                matched_next = '0;
                if (cur_sel_reg) begin
                    valid_a_next = '0;
                end else begin
                    valid_b_next = '0;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_id_next    = m_id_reg;
        m_x_next     = m_x_reg;
        m_y_next     = m_y_reg;
        m_size_next  = m_size_reg;
        m_full_next  = m_full_reg;
        m_last_next  = m_last_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_kind_next  = emit_kind;
            m_id_next    = wid_reg;
            m_x_next     = sx_reg;
            m_y_next     = sy_reg;
            m_size_next  = ssz_reg;
            m_full_next  = wfull_reg;
            m_last_next  = end_mode_reg ? (emit_final && last_grp_reg) : emit_final;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            width_reg   <= SCREEN_WIDTH_RST;
            height_reg  <= SCREEN_HEIGHT_RST;
            cur_sel_reg <= 1'b0;
            valid_a_reg <= '0;
            valid_b_reg <= '0;
            matched_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            cur_sel_reg <= cur_sel_next;
            valid_a_reg <= valid_a_next;
            valid_b_reg <= valid_b_next;
            matched_reg <= matched_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        wid_reg        <= wid_next;
        wx_reg         <= wx_next;
        wy_reg         <= wy_next;
        wsz_reg        <= wsz_next;
        wfull_reg      <= wfull_next;
        end_mode_reg   <= end_mode_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        dup_found_reg  <= dup_found_next;
        dup_idx_reg    <= dup_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        best_found_reg <= best_found_next;
        best_idx_reg   <= best_idx_next;
        best_id_reg    <= best_id_next;
        count_reg      <= count_next;
        last_grp_reg   <= last_grp_next;
        phase_reg      <= phase_next;
        mstep_reg      <= mstep_next;
        sx_reg         <= sx_next;
        sy_reg         <= sy_next;
        ssz_reg        <= ssz_next;
        m_kind_reg     <= m_kind_next;
        m_id_reg       <= m_id_next;
        m_x_reg        <= m_x_next;
        m_y_reg        <= m_y_next;
        m_size_reg     <= m_size_next;
        m_full_reg     <= m_full_next;
        m_last_reg     <= m_last_next;
    end

    // contact tables, written at one entry of the current bank
    always_ff @(posedge aclk) begin
        if (store_we) begin
            if (cur_sel_reg) begin
                ident_b_reg[store_idx] <= wid_reg;
                xpos_b_reg[store_idx]  <= wx_reg;
                ypos_b_reg[store_idx]  <= wy_reg;
                csize_b_reg[store_idx] <= wsz_reg;
            end else begin
                ident_a_reg[store_idx] <= wid_reg;
                xpos_a_reg[store_idx]  <= wx_reg;
                ypos_a_reg[store_idx]  <= wy_reg;
                csize_a_reg[store_idx] <= wsz_reg;
            end
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_event_kind  = m_kind_reg;
    assign m_event_id    = m_id_reg;
    assign m_screen_x    = m_x_reg;
    assign m_screen_y    = m_y_reg;
    assign m_scaled_size = m_size_reg;
    assign m_table_full  = m_full_reg;
    assign m_last        = m_last_reg;

    // a move always closes its transaction, an up never does
    a_move_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_kind == EV_MOVE)) |-> m_last)
        else $error("move event without last");

    a_up_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_kind == EV_UP)) |-> !m_last)
        else $error("up event marked last");

    // frame end only reports stored contacts
    a_no_full_on_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ((m_event_kind == EV_UP) || (m_event_kind == EV_LEAVE)))
        |-> !m_table_full)
        else $error("table full flag on up or leave");

    // after the swap the new current bank is empty and nothing is matched
    a_swap_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWAP)
        |=> (((cur_sel_reg ? valid_b_reg : valid_a_reg) == '0) && (matched_reg == '0)))
        else $error("current table not empty after frame swap");

endmodule

[dv/tb_touch_contact_event_tracker_core.sv]
// self-checking testbench for the touch contact event tracker core
`timescale 1ns / 1ps

module tb_touch_contact_event_tracker_core;
    import tcet_pkg::*;

    localparam int MAX_CONTACTS     = MAX_CONTACTS_DEF;
    // idle stretch long enough for the block to finish after its last event
    localparam int SETTLE_CYCLES    = 4 * MAX_CONTACTS + 16;
    localparam int LIMIT_CYCLES     = 1_000_000;
    localparam int RANDOM_PHASES    = 6;
    localparam int RANDOM_PER_PHASE = 67;
    localparam int IDLE_PCT         = 27;
    // accepted-transaction window in which neither side idles
    localparam int STEADY_FROM      = 150;
    localparam int STEADY_TO        = 260;

    typedef enum logic [1:0] {
        STIM_ITEM,
        STIM_SCALE,
        STIM_SETTLE
    } stim_op_t;

    typedef struct {
        stim_op_t            op;
        logic                cmd;
        logic [ID_W-1:0]     id;
        logic [POS_W-1:0]    px;
        logic [POS_W-1:0]    py;
        logic [SIZE_W-1:0]   sz;
        logic [0:0]          reg_idx;
        logic [SCALE_W-1:0]  reg_val;
    } stim_entry_t;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [ID_W-1:0]     id;
        logic [SCR_W-1:0]    sx;
        logic [SCR_W-1:0]    sy;
        logic [SSIZE_W-1:0]  ssize;
        logic                full;
        logic                last;
    } touch_event_t;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic                s_cmd          = CMD_CONTACT;
    logic [ID_W-1:0]     s_contact_id   = '0;
    logic [POS_W-1:0]    s_pos_x        = '0;
    logic [POS_W-1:0]    s_pos_y        = '0;
    logic [SIZE_W-1:0]   s_contact_size = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [KIND_W-1:0]   m_event_kind;
    logic [ID_W-1:0]     m_event_id;
    logic [SCR_W-1:0]    m_screen_x;
    logic [SCR_W-1:0]    m_screen_y;
    logic [SSIZE_W-1:0]  m_scaled_size;
    logic                m_table_full;
    logic                m_last;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic [0:0]          cfg_index      = CFG_SCREEN_WIDTH;
    logic [SCALE_W-1:0]  cfg_data       = '0;

    // transaction taken at the last rising edge, seen by the driver at the falling edge
    logic s_fire_q   = 1'b0;
    logic cfg_fire_q = 1'b0;

    stim_entry_t  stim_q[$];
    touch_event_t pending_events[$];

    // tracker image kept by the testbench
    logic [SCALE_W-1:0] scale_w_q = SCREEN_WIDTH_RST;
    logic [SCALE_W-1:0] scale_h_q = SCREEN_HEIGHT_RST;
    logic               prv_live  [MAX_CONTACTS] = '{default: 1'b0};
    logic               prv_taken [MAX_CONTACTS] = '{default: 1'b0};
    logic [ID_W-1:0]    prv_id    [MAX_CONTACTS];
    logic [POS_W-1:0]   prv_x     [MAX_CONTACTS];
    logic [POS_W-1:0]   prv_y     [MAX_CONTACTS];
    logic [SIZE_W-1:0]  prv_sz    [MAX_CONTACTS];
    logic               cur_live  [MAX_CONTACTS] = '{default: 1'b0};
    logic [ID_W-1:0]    cur_id    [MAX_CONTACTS];
    logic [POS_W-1:0]   cur_x     [MAX_CONTACTS];
    logic [POS_W-1:0]   cur_y     [MAX_CONTACTS];
    logic [SIZE_W-1:0]  cur_sz    [MAX_CONTACTS];

    // generator bookkeeping: ids of the last closed frame and the open one
    logic [ID_W-1:0] gen_prev[$];
    logic [ID_W-1:0] gen_cur[$];
    int gen_items = 0;

    int errors         = 0;
    int items_in       = 0;
    int contacts_in    = 0;
    int frame_ends_in  = 0;
    int events_checked = 0;
    int full_events    = 0;
    int cfg_writes     = 0;
    int quiet_cnt      = 0;

    logic steady;
    assign steady = (items_in >= STEADY_FROM) && (items_in < STEADY_TO);

    touch_contact_event_tracker_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_contact_id   (s_contact_id),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_contact_size (s_contact_size),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_event_id     (m_event_id),
        .m_screen_x     (m_screen_x),
        .m_screen_y     (m_screen_y),
        .m_scaled_size  (m_scaled_size),
        .m_table_full   (m_table_full),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(string msg);
        if (errors < 100) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        errors++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("event %0d %s: got %0d, expected %0d",
                                      events_checked, name, got, want));
        end
    endtask

    // normalized position times scale, top 13 bits saturate
    function automatic logic [SCR_W-1:0] to_screen(logic [POS_W-1:0] pos,
                                                   logic [SCALE_W-1:0] scale);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(pos) * PROD_W'(scale);
        if (prod[PROD_W-1]) begin
            return '1;
        end
        return prod[PROD_W-2:POS_W];
    endfunction

    function automatic void push_event(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                       logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                       logic [SIZE_W-1:0] sz, logic full, logic last);
        touch_event_t ev;
        ev.kind  = kind;
        ev.id    = id;
        ev.sx    = to_screen(px, scale_w_q);
        ev.sy    = to_screen(py, scale_h_q);
        ev.ssize = SSIZE_W'(sz) * SSIZE_W'(SIZE_FACTOR);
        ev.full  = full;
        ev.last  = last;
        pending_events.insert(pending_events.size(), ev);
    endfunction

    // one contact: move if its id is an unmatched previous one, else enter and down
    function automatic void track_contact(logic [ID_W-1:0] id, logic [POS_W-1:0] px,
                                          logic [POS_W-1:0] py, logic [SIZE_W-1:0] sz);
        int hit;
        int slot;
        logic full;
        hit  = -1;
        slot = -1;
        for (int i = 0; i < MAX_CONTACTS; i++) begin
            if (hit < 0 && prv_live[i] && !prv_taken[i] && prv_id[i] == id) hit = i;
        end
        // a repeated id reuses its entry, otherwise the lowest free one
        for (int i = 0; i < MAX_CONTACTS; i++) begin
            if (slot < 0 && cur_live[i] && cur_id[i] == id) slot = i;
        end
        for (int i = 0; i < MAX_CONTACTS; i++) begin
            if (slot < 0 && !cur_live[i]) slot = i;
        end
        full = (slot < 0);
        if (!full) begin
            cur_live[slot] = 1'b1;
            cur_id[slot]   = id;
            cur_x[slot]    = px;
            cur_y[slot]    = py;
            cur_sz[slot]   = sz;
        end
        if (hit >= 0) begin
            prv_taken[hit] = 1'b1;
            push_event(EV_MOVE, id, px, py, sz, full, 1'b1);
        end else begin
            push_event(EV_ENTER, id, px, py, sz, full, 1'b0);
            push_event(EV_DOWN, id, px, py, sz, full, 1'b1);
        end
    endfunction

    // end of frame: up and leave per unmatched previous contact, lowest id first
    function automatic void close_frame();
        logic done [MAX_CONTACTS];
        int best;
        int remaining;
        remaining = 0;
        for (int i = 0; i < MAX_CONTACTS; i++) begin
            done[i] = 1'b0;
            if (prv_live[i] && !prv_taken[i]) remaining++;
        end
        while (remaining > 0) begin
            best = -1;
            for (int i = 0; i < MAX_CONTACTS; i++) begin
                if (prv_live[i] && !prv_taken[i] && !done[i]) begin
                    if (best < 0) begin
                        best = i;
                    end else if (prv_id[i] < prv_id[best]) begin
                        best = i;
                    end
                end
            end
            done[best] = 1'b1;
            remaining--;
            push_event(EV_UP, prv_id[best], prv_x[best], prv_y[best], prv_sz[best],
                       1'b0, 1'b0);
            push_event(EV_LEAVE, prv_id[best], prv_x[best], prv_y[best], prv_sz[best],
                       1'b0, remaining == 0);
        end
        for (int i = 0; i < MAX_CONTACTS; i++) begin
            prv_live[i]  = cur_live[i];
            prv_taken[i] = 1'b0;
            prv_id[i]    = cur_id[i];
            prv_x[i]     = cur_x[i];
            prv_y[i]     = cur_y[i];
            prv_sz[i]    = cur_sz[i];
            cur_live[i]  = 1'b0;
        end
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void add_contact(logic [ID_W-1:0] id, logic [POS_W-1:0] px,
                                        logic [POS_W-1:0] py, logic [SIZE_W-1:0] sz);
        stim_entry_t e;
        e.op      = STIM_ITEM;
        e.cmd     = CMD_CONTACT;
        e.id      = id;
        e.px      = px;
        e.py      = py;
        e.sz      = sz;
        e.reg_idx = CFG_SCREEN_WIDTH;
        e.reg_val = '0;
        stim_q.insert(stim_q.size(), e);
        gen_cur.insert(gen_cur.size(), id);
        gen_items++;
    endfunction

    // frame end carries random payload, which the block ignores
    function automatic void add_frame_end();
        stim_entry_t e;
        e.op      = STIM_ITEM;
        e.cmd     = CMD_END_FRAME;
        e.id      = 8'($urandom);
        e.px      = pick_word();
        e.py      = pick_word();
        e.sz      = pick_word();
        e.reg_idx = CFG_SCREEN_WIDTH;
        e.reg_val = '0;
        stim_q.insert(stim_q.size(), e);
        gen_prev = gen_cur;
        gen_cur.delete();
        gen_items++;
    endfunction

    function automatic void add_settle();
        stim_entry_t e;
        e = '{op: STIM_SETTLE, cmd: CMD_CONTACT, id: '0, px: '0, py: '0, sz: '0,
              reg_idx: CFG_SCREEN_WIDTH, reg_val: '0};
        stim_q.insert(stim_q.size(), e);
    endfunction

    function automatic void add_scale(logic [SCALE_W-1:0] w, logic [SCALE_W-1:0] h);
        stim_entry_t e;
        e = '{op: STIM_SCALE, cmd: CMD_CONTACT, id: '0, px: '0, py: '0, sz: '0,
              reg_idx: CFG_SCREEN_WIDTH, reg_val: w};
        stim_q.insert(stim_q.size(), e);
        e.reg_idx = CFG_SCREEN_HEIGHT;
        e.reg_val = h;
        stim_q.insert(stim_q.size(), e);
    endfunction

    // mostly plausible frames: ids carried over, some repeats, some fresh
    function automatic void add_random_frame();
        int n;
        int r;
        logic [ID_W-1:0] id;
        if ($urandom_range(99) < 7) begin
            n = $urandom_range(MAX_CONTACTS + 3, MAX_CONTACTS - 2);
        end else begin
            n = $urandom_range(5);
        end
        for (int c = 0; c < n; c++) begin
            r = $urandom_range(99);
            if (r < 55 && gen_prev.size() != 0) begin
                id = gen_prev[$urandom_range(gen_prev.size() - 1)];
            end else if (r < 68 && gen_cur.size() != 0) begin
                id = gen_cur[$urandom_range(gen_cur.size() - 1)];
            end else if (r < 84) begin
                id = 8'($urandom_range(15));
            end else begin
                id = 8'($urandom);
            end
            add_contact(id, pick_word(), pick_word(), pick_word());
        end
        // now and then a frame runs on without its end, or ends twice
        if ($urandom_range(99) >= 5) add_frame_end();
        if ($urandom_range(99) < 6) add_frame_end();
    endfunction

    // input side: one assignment per signal per falling edge
    always @(negedge aclk) begin : drive_inputs
        logic hold_s;
        logic hold_cfg;
        logic idle_now;
        stim_entry_t head;
        hold_s   = s_valid && !s_fire_q;
        hold_cfg = cfg_valid && !cfg_fire_q;
        idle_now = !steady && ($urandom_range(99) < IDLE_PCT);
        // count cycles with nothing outstanding before any configuration write
        if (pending_events.size() == 0 && !s_valid && !m_valid) begin
            if (quiet_cnt < SETTLE_CYCLES) quiet_cnt <= quiet_cnt + 1;
        end else begin
            quiet_cnt <= 0;
        end
        if (aresetn && !hold_s && !hold_cfg && stim_q.size() != 0) begin
            head = stim_q[0];
            case (head.op)
                STIM_ITEM: begin
                    if (!idle_now) begin
                        s_cmd          <= head.cmd;
                        s_contact_id   <= head.id;
                        s_pos_x        <= head.px;
                        s_pos_y        <= head.py;
                        s_contact_size <= head.sz;
                        hold_s = 1'b1;
                        void'(stim_q.pop_front());
                    end
                end
                STIM_SCALE: begin
                    if (quiet_cnt >= SETTLE_CYCLES) begin
                        cfg_index <= head.reg_idx;
                        cfg_data  <= head.reg_val;
                        hold_cfg = 1'b1;
                        void'(stim_q.pop_front());
                    end
                end
                default: begin
                    // sender holds off until every event has drained
                    if (quiet_cnt >= SETTLE_CYCLES) void'(stim_q.pop_front());
                end
            endcase
        end
        s_valid   <= hold_s;
        cfg_valid <= hold_cfg;
    end

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // rising edge: register transactions, predict, and check events
    always @(posedge aclk) begin : watch_ports
        touch_event_t want;
        s_fire_q   <= s_valid && s_ready;
        cfg_fire_q <= cfg_valid && cfg_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SCREEN_WIDTH) begin
                    scale_w_q = cfg_data;
                end else begin
                    scale_h_q = cfg_data;
                end
                cfg_writes++;
            end
            if (s_valid && s_ready) begin
                if (s_cmd == CMD_CONTACT) begin
                    track_contact(s_contact_id, s_pos_x, s_pos_y, s_contact_size);
                    contacts_in++;
                end else begin
                    close_frame();
                    frame_ends_in++;
                end
                items_in++;
            end
            if (m_valid && m_ready) begin
                if (pending_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected event kind %0d id %0d",
                                              m_event_kind, m_event_id));
                end else begin
                    want = pending_events.pop_front();
                    compare_field("event_kind", 32'(m_event_kind), 32'(want.kind));
                    compare_field("event_id", 32'(m_event_id), 32'(want.id));
                    compare_field("screen_x", 32'(m_screen_x), 32'(want.sx));
                    compare_field("screen_y", 32'(m_screen_y), 32'(want.sy));
                    compare_field("scaled_size", 32'(m_scaled_size), 32'(want.ssize));
                    compare_field("table_full", 32'(m_table_full), 32'(want.full));
                    compare_field("last", 32'(m_last), 32'(want.last));
                    if (want.full) full_events++;
                end
                events_checked++;
            end
        end
    end

    initial begin
        logic [SCALE_W-1:0] w_set [RANDOM_PHASES] = '{14'd8192, 14'd1, 14'd16383,
                                                      14'd0, 14'd1920, 14'd0};
        logic [SCALE_W-1:0] h_set [RANDOM_PHASES] = '{14'd8192, 14'd1, 14'd16383,
                                                      14'd8191, 14'd1080, 14'd0};
        int directed_items;

        // frame with field extremes, closed with nothing to release
        add_contact(8'd0, 16'h0000, 16'h0000, 16'h0000);
        add_contact(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_contact(8'd7, 16'h8000, 16'h4000, 16'h1000);
        add_frame_end();
        // repeated id: first one moves, second enters and overwrites; 7 goes up
        add_contact(8'd255, 16'h1234, 16'hEDCB, 16'h0800);
        add_contact(8'd255, 16'hAAAA, 16'h5555, 16'h7FFF);
        add_contact(8'd0, 16'h0001, 16'hFFFE, 16'h0001);
        add_frame_end();
        // fill the table, then a new id and a carried id while full, then a repeat
        for (int i = 0; i < MAX_CONTACTS; i++) begin
            add_contact(8'(i), 16'(i * 4096), 16'(65535 - i * 4096), 16'(i * 4369));
        end
        add_contact(8'd16, 16'hC000, 16'h3000, 16'hF000);
        add_contact(8'd255, 16'hFFFF, 16'h0000, 16'hFFFF);
        add_contact(8'd3, 16'h7777, 16'h8888, 16'h9999);
        // everything previous was matched: no event; then a full release
        add_frame_end();
        add_frame_end();
        directed_items = gen_items;

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == RANDOM_PHASES - 1) begin
                add_scale(14'($urandom_range(8192, 1)), 14'($urandom_range(8192, 1)));
            end else begin
                add_scale(w_set[p], h_set[p]);
            end
            add_random_frame();
            add_settle();
            while (gen_items < directed_items + (p + 1) * RANDOM_PER_PHASE) begin
                add_random_frame();
                if ($urandom_range(99) < 3) add_settle();
            end
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (stim_q.size() != 0 || s_valid || cfg_valid || pending_events.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d contacts and %0d frame ends under %0d register writes",
                 contacts_in, frame_ends_in, cfg_writes);
        $display("checked %0d events, %0d of them with the table full, %0d mismatches",
                 events_checked, full_events, errors);
        if (errors == 0) begin
            $display("touch_contact_event_tracker_core regression: pass");
        end else begin
            $display("touch_contact_event_tracker_core regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("timeout with %0d events outstanding", pending_events.size());
        $display("touch_contact_event_tracker_core regression: fail");
        $finish;
    end

endmodule
